// ----- rtl/pbrd_pkg.sv -----
// Package for the PackBits row decoder: field widths, register map and
// default dimensions. No dependencies; every other file imports it.
package pbrd_pkg;

    // Field widths of the byte and run words
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;
    localparam int POS_W  = 11;

    // Configuration port
    localparam int CFG_W       = 12;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_INDEX_W = 1;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reset value of both dimension registers
    localparam logic [CFG_W-1:0] DIM_RESET = 12'd1;

    // Largest supported width or height
    localparam int MAX_DIM_DEFAULT = 2048;

    // PackBits header codes
    localparam logic [BYTE_W-1:0] LITERAL_HDR_MAX = 8'd127;
    localparam logic [BYTE_W:0]   REPEAT_BASE     = 9'd257;

endpackage

// ----- rtl/pbrd_ifs.sv -----
// Channel interfaces of the PackBits row decoder: compressed byte input
// and decoded run output. Depends on pbrd_pkg.
interface pbrd_byte_if;
    import pbrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              image_start;

    modport source (output valid, output code_byte, output image_start, input ready);
    modport sink   (input valid, input code_byte, input image_start, output ready);
endinterface

interface pbrd_run_if;
    import pbrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_value;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-1:0]  start_column;
    logic [POS_W-1:0]  start_row;
    logic              image_done;
    logic              overrun_error;

    modport source (output valid, output pixel_value, output run_length,
                    output start_column, output start_row, output image_done,
                    output overrun_error, input ready);
    modport sink   (input valid, input pixel_value, input run_length,
                    input start_column, input start_row, input image_done,
                    input overrun_error, output ready);
endinterface

// ----- rtl/pbrd_regs.sv -----
// APB-style register file for image width and height, with clamped copies
// for the decoder. Depends on pbrd_pkg.
module pbrd_regs #(
    parameter int MAX_DIM = pbrd_pkg::MAX_DIM_DEFAULT,
    parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbrd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pbrd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pbrd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [DIM_W-1:0]                    width_eff,
    output logic [DIM_W-1:0]                    height_eff
);
    import pbrd_pkg::*;

    localparam int CW = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    logic [CFG_W-1:0]       width_raw_reg;
    logic [CFG_W-1:0]       height_raw_reg;
    logic [DIM_W-1:0]       width_eff_reg;
    logic [DIM_W-1:0]       height_eff_reg;
    logic                   wr_en;
    logic [REG_INDEX_W-1:0] wr_index;
    logic [CFG_W-1:0]       wr_value;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ve;
        begin
            ve = CW'(v);
            if (v == '0)
                return DIM_W'(1);
            else if (ve > CW'(MAX_DIM))
                return DIM_W'(MAX_DIM);
            else
                return DIM_W'(ve);
        end
    endfunction

    assign wr_en    = psel && penable && pwrite;
    assign wr_index = paddr[2];
    assign wr_value = pwdata[CFG_W-1:0];

    // Hold raw and clamped register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= DIM_RESET;
            height_raw_reg <= DIM_RESET;
            width_eff_reg  <= clamp_dim(DIM_RESET);
            height_eff_reg <= clamp_dim(DIM_RESET);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_IMAGE_WIDTH:
                begin
                    width_raw_reg <= wr_value;
                    width_eff_reg <= clamp_dim(wr_value);
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_raw_reg <= wr_value;
                    height_eff_reg <= clamp_dim(wr_value);
                end
                default:
                begin
                    width_raw_reg <= width_raw_reg;
                end
            endcase
        end
    end

    // Read back the raw values
    always_comb
    begin
        unique case (wr_index)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_raw_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_raw_reg);
            default:          prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign width_eff  = width_eff_reg;
    assign height_eff = height_eff_reg;

endmodule

// ----- rtl/pbrd_decode.sv -----
// Decode datapath: input word register, PackBits phase and position state,
// and the result word register. Depends on pbrd_pkg and pbrd_ifs.
module pbrd_decode #(
    parameter int MAX_DIM = pbrd_pkg::MAX_DIM_DEFAULT,
    parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] width_eff,
    input  logic [DIM_W-1:0] height_eff,
    pbrd_byte_if.sink        byte_in,
    pbrd_run_if.source       run_out
);
    import pbrd_pkg::*;

    localparam int CMP_W = (DIM_W > LEN_W) ? DIM_W : LEN_W;
    localparam int PW    = (DIM_W > POS_W) ? DIM_W : POS_W;

    typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} phase_t;

    // Input word register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              start_reg;

    // Decoder state
    phase_t            phase_reg,   phase_next;
    logic [LEN_W-1:0]  lit_reg,     lit_next;
    logic [LEN_W-1:0]  rep_reg,     rep_next;
    logic [DIM_W-1:0]  col_reg,     col_next;
    logic [DIM_W-1:0]  row_reg,     row_next;
    logic              halted_reg,  halted_next;

    // Result word register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] pixel_reg;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic [POS_W-1:0]  scol_reg,    scol_next;
    logic [POS_W-1:0]  srow_reg,    srow_next;
    logic              done_reg,    done_next;
    logic              err_reg,     err_next;
    logic              has_result;

    // State as seen by the current word after an image start
    phase_t            phase_eff;
    logic [LEN_W-1:0]  lit_eff;
    logic [LEN_W-1:0]  rep_eff;
    logic [DIM_W-1:0]  col_eff;
    logic [DIM_W-1:0]  row_eff;
    logic              halted_eff;

    logic              step_fire;
    logic              in_ready;
    logic [DIM_W-1:0]  space;
    logic [LEN_W-1:0]  want;
    logic              cut;
    logic [LEN_W-1:0]  len;
    logic [DIM_W-1:0]  col_sum;
    logic [DIM_W-1:0]  row_inc;
    logic              row_full;
    phase_t            phase_after;

    // Advance when the result register is free or being drained
    assign step_fire = in_valid_reg && (!out_valid_reg || run_out.ready);
    assign in_ready  = !in_valid_reg || step_fire;
    assign byte_in.ready = in_ready;

    // Load the input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && byte_in.valid)
        begin
            byte_reg  <= byte_in.code_byte;
            start_reg <= byte_in.image_start;
        end
    end

    // Apply image start to the state
    always_comb
    begin
        phase_eff  = start_reg ? PH_HEADER : phase_reg;
        lit_eff    = start_reg ? '0 : lit_reg;
        rep_eff    = start_reg ? '0 : rep_reg;
        col_eff    = start_reg ? '0 : col_reg;
        row_eff    = start_reg ? '0 : row_reg;
        halted_eff = start_reg ? 1'b0 : halted_reg;
    end

    // Run length and column arithmetic
    always_comb
    begin
        space    = width_eff - col_eff;
        want     = (phase_eff == PH_LITERAL) ? LEN_W'(1) : rep_eff;
        cut      = CMP_W'(want) > CMP_W'(space);
        len      = cut ? LEN_W'(space) : want;
        col_sum  = col_eff + DIM_W'(len);
        row_inc  = row_eff + DIM_W'(1);
        row_full = col_eff >= width_eff;
        if (phase_eff == PH_REPEAT || lit_eff == LEN_W'(1))
            phase_after = PH_HEADER;
        else
            phase_after = PH_LITERAL;
    end

    // Next state and result word
    always_comb
    begin
        phase_next  = phase_eff;
        lit_next    = lit_eff;
        rep_next    = rep_eff;
        col_next    = col_eff;
        row_next    = row_eff;
        halted_next = halted_eff;
        has_result  = 1'b0;
        len_next    = '0;
        scol_next   = '0;
        srow_next   = POS_W'(PW'(row_eff));
        done_next   = 1'b0;
        err_next    = 1'b0;

        if (!halted_eff)
        begin
            if (phase_eff == PH_HEADER)
            begin
                // Header: open a literal or a repeat
                if (byte_reg <= LITERAL_HDR_MAX)
                begin
                    phase_next = PH_LITERAL;
                    lit_next   = byte_reg + LEN_W'(1);
                end
                else
                begin
                    phase_next = PH_REPEAT;
                    rep_next   = LEN_W'(REPEAT_BASE - {1'b0, byte_reg});
                end
            end
            else if (row_full)
            begin
                // Row already full: refuse the data byte and stop
                has_result  = 1'b1;
                err_next    = 1'b1;
                halted_next = 1'b1;
            end
            else
            begin
                has_result = 1'b1;
                len_next   = len;
                scol_next  = POS_W'(PW'(col_eff));
                col_next   = col_sum;
                phase_next = phase_after;
                if (phase_eff == PH_LITERAL)
                    lit_next = lit_eff - LEN_W'(1);
                else
                    rep_next = '0;

                if (cut)
                begin
                    err_next    = 1'b1;
                    halted_next = 1'b1;
                end
                else if (phase_after == PH_HEADER && col_sum >= width_eff)
                begin
                    // Wrap to the next row, finish on the last one
                    col_next = '0;
                    row_next = row_inc;
                    if (row_inc >= height_eff)
                    begin
                        done_next   = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold decoder state and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            lit_reg       <= '0;
            rep_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            phase_reg     <= phase_next;
            lit_reg       <= lit_next;
            rep_reg       <= rep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            halted_reg    <= halted_next;
            out_valid_reg <= has_result;
        end
        else if (run_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && has_result)
        begin
            pixel_reg <= byte_reg;
            len_reg   <= len_next;
            scol_reg  <= scol_next;
            srow_reg  <= srow_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

    assign run_out.valid         = out_valid_reg;
    assign run_out.pixel_value   = pixel_reg;
    assign run_out.run_length    = len_reg;
    assign run_out.start_column  = scol_reg;
    assign run_out.start_row     = srow_reg;
    assign run_out.image_done    = done_reg;
    assign run_out.overrun_error = err_reg;

    // A finished or failed run leaves the decoder halted while it waits
    a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (done_reg || err_reg) |-> halted_reg)
        else $error("decoder not halted behind a final or failed run");

    // An overrun never completes the image
    a_err_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> !done_reg)
        else $error("run flagged both overrun and image done");

    // A zero-length run is only a refusal
    a_zero_len_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (len_reg == '0) |-> err_reg)
        else $error("zero-length run without overrun");

    // A halted decoder drops words without an image start
    a_halted_drops: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && halted_reg && !start_reg |=> !out_valid_reg)
        else $error("result produced while halted");

    // A literal in progress always has bytes left
    a_literal_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LITERAL |-> lit_reg != '0)
        else $error("literal phase with no bytes left");

endmodule

// ----- rtl/packbits_row_decoder_top.sv -----
// PackBits row decoder: takes one compressed byte per cycle on byte_in while
// run_out drains and gives one run word on run_out for each data byte; header
// bytes, and every byte after an overrun or the last row until the next
// image start, give no word. Each byte passes an input register and then a
// result register before its run word is valid on run_out, and a new byte is
// taken every cycle while run_out drains; the column and row update is
// combinational. Image width and height are written over the APB port at
// byte addresses 0 and 4, by the user only while the decoder is idle; the
// block does not enforce it. Zero acts as one and values above MAX_DIM act as MAX_DIM.
// Depends on pbrd_pkg, pbrd_ifs, pbrd_regs and pbrd_decode.
module packbits_row_decoder_top #(
    parameter int MAX_DIM = pbrd_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbrd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbrd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pbrd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    pbrd_byte_if.sink                       byte_in,
    pbrd_run_if.source                      run_out
);
    import pbrd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    // Configuration registers
    pbrd_regs #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .width_eff  (width_eff),
        .height_eff (height_eff)
    );

    // Decode datapath
    pbrd_decode #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .byte_in    (byte_in),
        .run_out    (run_out)
    );

endmodule
